// ===== rtl/rkas_pkg.sv =====
// Shared widths, register codes and reset values for the rotary knob setpoint unit.
package rkas_pkg;

    localparam int SETPOINT_WIDTH = 20;
    localparam int COUNT_WIDTH    = 16;

    // Fixed field widths of the channels and the register port
    localparam int STEP_WIDTH  = 16;
    localparam int LIMIT_WIDTH = 20;
    localparam int CFG_WIDTH   = 20;
    localparam int OUT_SP_W    = 20;
    localparam int OUT_RATE_W  = 16;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    // Bit positions in m_tdata
    localparam int M_SP_LSB    = 0;
    localparam int M_RATE_LSB  = M_SP_LSB + OUT_SP_W;
    localparam int M_KNOB_BIT  = M_RATE_LSB + OUT_RATE_W;
    localparam int M_FLASH_BIT = M_KNOB_BIT + 1;

    // Bit positions in s_tdata
    localparam int S_B_LEVEL_BIT = 0;
    localparam int S_STOPPED_BIT = 1;

    // Compare widths wide enough for either operand
    localparam int SP_CMP_W  = (SETPOINT_WIDTH > LIMIT_WIDTH) ? SETPOINT_WIDTH + 1
                                                              : LIMIT_WIDTH + 1;
    localparam int CNT_CMP_W = (COUNT_WIDTH > STEP_WIDTH) ? COUNT_WIDTH : STEP_WIDTH;

    typedef enum logic [2:0] {
        CFG_SMALL_STEP      = 3'd0,
        CFG_LARGE_STEP      = 3'd1,
        CFG_FAST_THRESHOLD  = 3'd2,
        CFG_UPPER_LIMIT     = 3'd3,
        CFG_FLOOR_THRESHOLD = 3'd4,
        CFG_FLOOR_VALUE     = 3'd5,
        CFG_WINDOW_TICKS    = 3'd6,
        CFG_KNOB_HOLD_TICKS = 3'd7
    } cfg_index_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_TURN = 1'b1
    } opcode_t;

    localparam logic [STEP_WIDTH-1:0]  RST_SMALL_STEP      = 16'd60;
    localparam logic [STEP_WIDTH-1:0]  RST_LARGE_STEP      = 16'd600;
    localparam logic [STEP_WIDTH-1:0]  RST_FAST_THRESHOLD  = 16'd20;
    localparam logic [LIMIT_WIDTH-1:0] RST_UPPER_LIMIT     = 20'd86400;
    localparam logic [LIMIT_WIDTH-1:0] RST_FLOOR_THRESHOLD = 20'd60;
    localparam logic [LIMIT_WIDTH-1:0] RST_FLOOR_VALUE     = 20'd0;
    localparam logic [STEP_WIDTH-1:0]  RST_WINDOW_TICKS    = 16'd1000;
    localparam logic [STEP_WIDTH-1:0]  RST_KNOB_HOLD_TICKS = 16'd1000;

endpackage

// ===== rtl/rotary_knob_accelerated_setpoint_unit.sv =====
// Top level: velocity-accelerated knob setpoint with rate window and knob-active timer.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+----------------------------------------------
//  s_*     | in        | s_tvalid/s_tready | tuser: opcode; tdata: b_level, motor_stopped
//  m_*     | out       | m_tvalid/m_tready | tdata: setpoint, rate, knob_active, flash
//  cfg_*   | in        | cfg_we            | cfg_index selects register, cfg_data value
//
// Requests update the state registers at acceptance and each result is registered:
// it goes into the output register, or into the skid register while the output stalls.
// A second result register (skid stage) lets one more request in while the output
// stalls; s_tready drops only when both hold results.
// Reset clears the channel state and the valid flags and loads the register defaults.
module rotary_knob_accelerated_setpoint_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rkas_pkg::S_TDATA_W-1:0] s_tdata,   // [0] b_level, [1] motor_stopped
    input  logic                           s_tuser,   // [0] opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [19:0] setpoint_value, [35:20] measured_rate, [36] knob_active, [37] flash_request
    output logic [rkas_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_we,
    input  logic [2:0]                     cfg_index,
    input  logic [rkas_pkg::CFG_WIDTH-1:0] cfg_data
);
    import rkas_pkg::*;

    // Configuration registers
    logic [STEP_WIDTH-1:0]     small_step_reg;
    logic [STEP_WIDTH-1:0]     large_step_reg;
    logic [STEP_WIDTH-1:0]     fast_threshold_reg;
    logic [SETPOINT_WIDTH-1:0] upper_limit_reg;
    logic [LIMIT_WIDTH-1:0]    floor_threshold_reg;
    logic [SETPOINT_WIDTH-1:0] floor_value_reg;
    logic [STEP_WIDTH-1:0]     window_ticks_reg;
    logic [STEP_WIDTH-1:0]     knob_hold_ticks_reg;

    // Channel state
    logic [SETPOINT_WIDTH-1:0] setpoint_reg,     setpoint_next;
    logic [COUNT_WIDTH-1:0]    edge_counter_reg, edge_counter_next;
    logic [COUNT_WIDTH-1:0]    rate_latch_reg,   rate_latch_next;
    logic [COUNT_WIDTH-1:0]    window_timer_reg, window_timer_next;
    logic [COUNT_WIDTH-1:0]    knob_timer_reg,   knob_timer_next;
    logic                      flash_next;

    // Output and skid registers
    logic                 out_valid_reg,  out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg,   out_data_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic [M_TDATA_W-1:0] skid_data_reg,  skid_data_next;

    logic                 accept;
    logic                 pop;
    logic [M_TDATA_W-1:0] result;

    logic                      b_level;
    logic                      stopped;
    logic [COUNT_WIDTH-1:0]    wt_inc;
    logic                      window_close;
    logic [STEP_WIDTH-1:0]     step;
    logic [SP_CMP_W-1:0]       sum;
    logic [SETPOINT_WIDTH-1:0] diff;
    logic                      under_floor;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign b_level = s_tdata[S_B_LEVEL_BIT];
    assign stopped = s_tdata[S_STOPPED_BIT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_step_reg      <= RST_SMALL_STEP;
            large_step_reg      <= RST_LARGE_STEP;
            fast_threshold_reg  <= RST_FAST_THRESHOLD;
            upper_limit_reg     <= SETPOINT_WIDTH'(RST_UPPER_LIMIT);
            floor_threshold_reg <= RST_FLOOR_THRESHOLD;
            floor_value_reg     <= SETPOINT_WIDTH'(RST_FLOOR_VALUE);
            window_ticks_reg    <= RST_WINDOW_TICKS;
            knob_hold_ticks_reg <= RST_KNOB_HOLD_TICKS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SMALL_STEP:      small_step_reg      <= cfg_data[STEP_WIDTH-1:0];
                CFG_LARGE_STEP:      large_step_reg      <= cfg_data[STEP_WIDTH-1:0];
                CFG_FAST_THRESHOLD:  fast_threshold_reg  <= cfg_data[STEP_WIDTH-1:0];
                CFG_UPPER_LIMIT:     upper_limit_reg     <= SETPOINT_WIDTH'(cfg_data);
                CFG_FLOOR_THRESHOLD: floor_threshold_reg <= cfg_data[LIMIT_WIDTH-1:0];
                CFG_FLOOR_VALUE:     floor_value_reg     <= SETPOINT_WIDTH'(cfg_data);
                CFG_WINDOW_TICKS:    window_ticks_reg    <= cfg_data[STEP_WIDTH-1:0];
                CFG_KNOB_HOLD_TICKS: knob_hold_ticks_reg <= cfg_data[STEP_WIDTH-1:0];
            endcase
        end
    end

    // Per-request update
    always_comb
    begin
        setpoint_next     = setpoint_reg;
        edge_counter_next = edge_counter_reg;
        rate_latch_next   = rate_latch_reg;
        window_timer_next = window_timer_reg;
        knob_timer_next   = knob_timer_reg;
        flash_next        = 1'b0;

        wt_inc       = window_timer_reg + 1'b1;
        // A zero window length closes on every tick
        window_close = CNT_CMP_W'(wt_inc) >= CNT_CMP_W'(window_ticks_reg);
        step         = (CNT_CMP_W'(rate_latch_reg) < CNT_CMP_W'(fast_threshold_reg))
                       ? small_step_reg : large_step_reg;
        sum          = SP_CMP_W'(setpoint_reg) + SP_CMP_W'(step);
        diff         = setpoint_reg - SETPOINT_WIDTH'(step);
        under_floor  = (SP_CMP_W'(setpoint_reg) < SP_CMP_W'(step))
                       || (SP_CMP_W'(diff) < SP_CMP_W'(floor_threshold_reg));

        unique case (opcode_t'(s_tuser))
            OP_TICK:
            begin
                window_timer_next = wt_inc;
                if (window_close)
                begin
                    rate_latch_next   = edge_counter_reg;
                    edge_counter_next = '0;
                    window_timer_next = '0;
                end
                if (knob_timer_reg != '0)
                    knob_timer_next = knob_timer_reg - 1'b1;
            end
            OP_TURN:
            begin
                // Saturate the edge count
                if (edge_counter_reg != '1)
                    edge_counter_next = edge_counter_reg + 1'b1;
                if (!stopped)
                begin
                    flash_next      = 1'b1;
                    knob_timer_next = COUNT_WIDTH'(knob_hold_ticks_reg);
                    if (!b_level)
                        setpoint_next = (sum > SP_CMP_W'(upper_limit_reg))
                                        ? upper_limit_reg : sum[SETPOINT_WIDTH-1:0];
                    else
                        setpoint_next = under_floor ? floor_value_reg : diff;
                end
            end
        endcase

        result                                    = '0;
        result[M_SP_LSB +: OUT_SP_W]              = OUT_SP_W'(setpoint_next);
        result[M_RATE_LSB +: OUT_RATE_W]          = OUT_RATE_W'(rate_latch_next);
        result[M_KNOB_BIT]                        = (knob_timer_next != '0);
        result[M_FLASH_BIT]                       = flash_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg     <= '0;
            edge_counter_reg <= '0;
            rate_latch_reg   <= '0;
            window_timer_reg <= '0;
            knob_timer_reg   <= '0;
        end
        else if (accept)
        begin
            setpoint_reg     <= setpoint_next;
            edge_counter_reg <= edge_counter_next;
            rate_latch_reg   <= rate_latch_next;
            window_timer_reg <= window_timer_next;
            knob_timer_reg   <= knob_timer_next;
        end
    end

    // Output register plus skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_data_next  = result;
            end
        end
        else if (accept)
        begin
            // Output stalled: park the new result
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== rtl/rkas_checker.sv =====
// Port-level checks for the rotary knob setpoint unit, bound to the top level.
module rkas_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rkas_pkg::M_TDATA_W-1:0] m_tdata
);
    import rkas_pkg::*;

    logic                has_prev_reg;
    logic [OUT_SP_W-1:0] prev_sp_reg;

    // Track the setpoint of the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            has_prev_reg <= 1'b0;
        else if (m_tvalid && m_tready)
            has_prev_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            prev_sp_reg <= m_tdata[M_SP_LSB +: OUT_SP_W];
    end

    // Setpoint moves only on a result that carries a flash request
    a_sp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && has_prev_reg && !m_tdata[M_FLASH_BIT])
        |-> (m_tdata[M_SP_LSB +: OUT_SP_W] == prev_sp_reg))
        else $error("setpoint changed without flash request");

    // Backpressure only while a result waits
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no pending result");

    // A new result follows an accepted request
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without accepted request");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind rotary_knob_accelerated_setpoint_unit rkas_checker u_rkas_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/rotary_knob_accelerated_setpoint_unit_tb.sv =====
// Self-checking testbench for the rotary knob accelerated setpoint unit.
`timescale 1ns / 1ps

module rotary_knob_accelerated_setpoint_unit_tb;

    import rkas_pkg::*;

    typedef struct packed {
        opcode_t op;
        logic    b_level;
        logic    stopped;
    } knob_req_t;

    typedef struct packed {
        logic [OUT_SP_W-1:0]   setpoint_value;
        logic [OUT_RATE_W-1:0] measured_rate;
        logic                  knob_active;
        logic                  flash_request;
    } knob_result_t;

    localparam int SET_ALL_ZERO = 0;
    localparam int SET_ALL_ONES = 1;
    localparam int SET_RANDOM   = 2;

    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_REQUESTS = 115;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = OP_TICK;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we = 1'b0;
    logic [2:0]             cfg_index = '0;
    logic [CFG_WIDTH-1:0]   cfg_data = '0;

    rotary_knob_accelerated_setpoint_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Register shadow
    logic [STEP_WIDTH-1:0]     step_small;
    logic [STEP_WIDTH-1:0]     step_large;
    logic [STEP_WIDTH-1:0]     fast_edges;
    logic [SETPOINT_WIDTH-1:0] limit_high;
    logic [LIMIT_WIDTH-1:0]    floor_below;
    logic [SETPOINT_WIDTH-1:0] floor_level;
    logic [STEP_WIDTH-1:0]     window_len;
    logic [STEP_WIDTH-1:0]     hold_len;

    // Knob state
    logic [SETPOINT_WIDTH-1:0] setpoint;
    logic [COUNT_WIDTH-1:0]    edge_count;
    logic [COUNT_WIDTH-1:0]    last_rate;
    logic [COUNT_WIDTH-1:0]    window_count;
    logic [COUNT_WIDTH-1:0]    hold_count;

    knob_req_t    pending_requests[$];
    knob_result_t expected_results[$];
    knob_req_t    presented;
    logic [S_TDATA_W-1:0] packed_req;

    bit idling_on = 1'b1;
    int gap_left = 0;
    int stall_left = 0;
    int error_count = 0;
    int turn_count = 0;
    int tick_count = 0;
    int results_checked = 0;
    int settings_count = 0;

    function automatic void load_defaults();
        step_small   = RST_SMALL_STEP;
        step_large   = RST_LARGE_STEP;
        fast_edges   = RST_FAST_THRESHOLD;
        limit_high   = RST_UPPER_LIMIT;
        floor_below  = RST_FLOOR_THRESHOLD;
        floor_level  = RST_FLOOR_VALUE;
        window_len   = RST_WINDOW_TICKS;
        hold_len     = RST_KNOB_HOLD_TICKS;
        setpoint     = '0;
        edge_count   = '0;
        last_rate    = '0;
        window_count = '0;
        hold_count   = '0;
    endfunction

    // Apply one request to the knob state and return the result it produces
    function automatic knob_result_t advance_knob(knob_req_t req);
        knob_result_t              res;
        logic [SETPOINT_WIDTH:0]   sum;
        logic [SETPOINT_WIDTH-1:0] step;
        logic                      adjusted;
        adjusted = 1'b0;
        if (req.op == OP_TICK)
        begin
            window_count = window_count + 1'b1;
            if (window_count >= window_len)
            begin
                last_rate    = edge_count;
                edge_count   = '0;
                window_count = '0;
            end
            if (hold_count != '0)
                hold_count = hold_count - 1'b1;
        end
        else
        begin
            if (edge_count != '1)
                edge_count = edge_count + 1'b1;
            if (!req.stopped)
            begin
                hold_count = hold_len;
                step = (last_rate < fast_edges) ? SETPOINT_WIDTH'(step_small)
                                                : SETPOINT_WIDTH'(step_large);
                if (!req.b_level)
                begin
                    sum = {1'b0, setpoint} + {1'b0, step};
                    setpoint = (sum > {1'b0, limit_high}) ? limit_high
                                                          : sum[SETPOINT_WIDTH-1:0];
                end
                else if (setpoint < step || setpoint - step < floor_below)
                    setpoint = floor_level;
                else
                    setpoint = setpoint - step;
                adjusted = 1'b1;
            end
        end
        res.setpoint_value = setpoint;
        res.measured_rate  = last_rate;
        res.knob_active    = (hold_count != '0);
        res.flash_request  = adjusted;
        return res;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        if (!idling_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(advance_knob(presented));
                if (presented.op == OP_TURN)
                    turn_count++;
                else
                    tick_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    presented = pending_requests.pop_front();
                    packed_req = '0;
                    packed_req[S_B_LEVEL_BIT] = presented.b_level;
                    packed_req[S_STOPPED_BIT] = presented.stopped;
                    s_tdata  <= packed_req;
                    s_tuser  <= presented.op;
                    s_tvalid <= 1'b1;
                    gap_left = idle_len();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
        error_count++;
    endtask

    // Result monitor
    always @(posedge clk)
    begin
        knob_result_t got;
        knob_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.setpoint_value = m_tdata[M_SP_LSB +: OUT_SP_W];
                got.measured_rate  = m_tdata[M_RATE_LSB +: OUT_RATE_W];
                got.knob_active    = m_tdata[M_KNOB_BIT];
                got.flash_request  = m_tdata[M_FLASH_BIT];
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with no request outstanding", $realtime);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got.setpoint_value != want.setpoint_value)
                        report_mismatch("setpoint_value", 32'(got.setpoint_value),
                                        32'(want.setpoint_value));
                    if (got.measured_rate != want.measured_rate)
                        report_mismatch("measured_rate", 32'(got.measured_rate),
                                        32'(want.measured_rate));
                    if (got.knob_active != want.knob_active)
                        report_mismatch("knob_active", 32'(got.knob_active),
                                        32'(want.knob_active));
                    if (got.flash_request != want.flash_request)
                        report_mismatch("flash_request", 32'(got.flash_request),
                                        32'(want.flash_request));
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = idle_len();
            end
        end
    end

    task automatic write_register(cfg_index_t idx, logic [CFG_WIDTH-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_SMALL_STEP:      step_small  = value[STEP_WIDTH-1:0];
            CFG_LARGE_STEP:      step_large  = value[STEP_WIDTH-1:0];
            CFG_FAST_THRESHOLD:  fast_edges  = value[STEP_WIDTH-1:0];
            CFG_UPPER_LIMIT:     limit_high  = value[SETPOINT_WIDTH-1:0];
            CFG_FLOOR_THRESHOLD: floor_below = value;
            CFG_FLOOR_VALUE:     floor_level = value[SETPOINT_WIDTH-1:0];
            CFG_WINDOW_TICKS:    window_len  = value[STEP_WIDTH-1:0];
            CFG_KNOB_HOLD_TICKS: hold_len    = value[STEP_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    function automatic logic [CFG_WIDTH-1:0] pick_setting(cfg_index_t idx, int mode);
        logic                 wide;
        logic [CFG_WIDTH-1:0] junk;
        logic [CFG_WIDTH-1:0] ones;
        int                   r;
        wide = (idx == CFG_UPPER_LIMIT) || (idx == CFG_FLOOR_THRESHOLD) ||
               (idx == CFG_FLOOR_VALUE);
        ones = wide ? {CFG_WIDTH{1'b1}} : {{(CFG_WIDTH-STEP_WIDTH){1'b0}}, {STEP_WIDTH{1'b1}}};
        // upper bits of a 16-bit register must be dropped
        junk = wide ? '0 : {4'($urandom_range(0, 15)), {STEP_WIDTH{1'b0}}};
        if (mode == SET_ALL_ZERO)
            return junk;
        if (mode == SET_ALL_ONES)
            return {CFG_WIDTH{1'b1}};
        r = $urandom_range(0, 99);
        if (r < 12)
            return junk;
        if (r < 24)
            return ones | junk;
        case (idx)
            CFG_SMALL_STEP:      return junk | CFG_WIDTH'($urandom_range(1, 400));
            CFG_LARGE_STEP:      return junk | CFG_WIDTH'($urandom_range(1, 4000));
            CFG_FAST_THRESHOLD:  return junk | CFG_WIDTH'($urandom_range(1, 12));
            CFG_UPPER_LIMIT:     return CFG_WIDTH'($urandom_range(0, 3000));
            CFG_FLOOR_THRESHOLD: return CFG_WIDTH'($urandom_range(0, 500));
            CFG_FLOOR_VALUE:     return CFG_WIDTH'($urandom_range(0, 1500));
            CFG_WINDOW_TICKS:    return junk | CFG_WIDTH'($urandom_range(1, 12));
            default:             return junk | CFG_WIDTH'($urandom_range(1, 25));
        endcase
    endfunction

    task automatic program_registers(int mode);
        cfg_index_t idx;
        idx = idx.first();
        repeat (idx.num())
        begin
            write_register(idx, pick_setting(idx, mode));
            idx = idx.next();
        end
        end_writes();
    endtask

    function automatic void queue_request(opcode_t op, logic b_level, logic stopped);
        knob_req_t req;
        req.op      = op;
        req.b_level = b_level;
        req.stopped = stopped;
        pending_requests.push_back(req);
    endfunction

    // Turn bursts in one direction with ticks in between, plus some scatter
    function automatic void queue_random_traffic(int count);
        int   made;
        int   run;
        int   r;
        logic dir;
        made = 0;
        dir  = 1'($urandom_range(0, 1));
        while (made < count)
        begin
            r   = $urandom_range(0, 99);
            run = 0;
            if (r < 50)
            begin
                run = $urandom_range(1, 30);
                repeat (run)
                begin
                    if ($urandom_range(0, 9) == 0)
                        dir = ~dir;
                    queue_request(OP_TURN, dir, $urandom_range(0, 99) < 15);
                end
            end
            else if (r < 85)
            begin
                run = $urandom_range(1, 15);
                repeat (run)
                    queue_request(OP_TICK, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
            end
            else
            begin
                run = $urandom_range(1, 10);
                repeat (run)
                    queue_request(opcode_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
            end
            made += run;
        end
    endfunction

    // Hold until every request is taken and every result has come back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        load_defaults();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset values
        queue_request(OP_TURN, 1'b0, 1'b0);
        queue_request(OP_TURN, 1'b0, 1'b0);
        queue_request(OP_TURN, 1'b1, 1'b0);
        queue_request(OP_TURN, 1'b0, 1'b1);
        queue_request(OP_TICK, 1'b1, 1'b1);
        wait_idle();

        // zero small step, huge large step, every tick closes a window,
        // decrease below zero to a high floor, then overflow into the limit
        write_register(CFG_SMALL_STEP, 20'h0);
        write_register(CFG_LARGE_STEP, 20'h0FFFF);
        write_register(CFG_FAST_THRESHOLD, 20'd1);
        write_register(CFG_UPPER_LIMIT, 20'hFFFFF);
        write_register(CFG_FLOOR_THRESHOLD, 20'h0);
        write_register(CFG_FLOOR_VALUE, 20'hF0000);
        write_register(CFG_WINDOW_TICKS, 20'h0);
        write_register(CFG_KNOB_HOLD_TICKS, 20'd2);
        end_writes();
        queue_request(OP_TICK, 1'b0, 1'b0);
        queue_request(OP_TICK, 1'b0, 1'b0);
        queue_request(OP_TURN, 1'b0, 1'b0);
        queue_request(OP_TURN, 1'b1, 1'b1);
        queue_request(OP_TICK, 1'b0, 1'b0);
        queue_request(OP_TURN, 1'b1, 1'b0);
        queue_request(OP_TURN, 1'b1, 1'b0);
        queue_request(OP_TURN, 1'b0, 1'b0);
        queue_request(OP_TURN, 1'b0, 1'b0);
        queue_request(OP_TURN, 1'b0, 1'b0);
        queue_request(OP_TICK, 1'b0, 1'b0);
        queue_request(OP_TICK, 1'b0, 1'b0);
        queue_request(OP_TURN, 1'b0, 1'b1);
        queue_request(OP_TICK, 1'b0, 1'b0);
        wait_idle();

        // zero hold, zero limit, floor above everything
        write_register(CFG_SMALL_STEP, 20'h0FFFF);
        write_register(CFG_FAST_THRESHOLD, 20'h0FFFF);
        write_register(CFG_UPPER_LIMIT, 20'h0);
        write_register(CFG_FLOOR_THRESHOLD, 20'hFFFFF);
        write_register(CFG_FLOOR_VALUE, 20'd5);
        write_register(CFG_WINDOW_TICKS, 20'd3);
        write_register(CFG_KNOB_HOLD_TICKS, 20'h0);
        end_writes();
        queue_request(OP_TURN, 1'b0, 1'b0);
        queue_request(OP_TURN, 1'b1, 1'b0);
        queue_request(OP_TURN, 1'b1, 1'b1);
        queue_request(OP_TICK, 1'b0, 1'b0);
        queue_request(OP_TICK, 1'b0, 1'b0);
        queue_request(OP_TICK, 1'b0, 1'b0);
        wait_idle();

        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            idling_on = (k % 4 != 3);
            if (k == 0)
                program_registers(SET_ALL_ZERO);
            else if (k == 1)
                program_registers(SET_ALL_ONES);
            else
                program_registers(SET_RANDOM);
            queue_random_traffic(PHASE_REQUESTS);
            wait_idle();
        end

        repeat (10) @(posedge clk);
        $display("Covered %0d turns and %0d ticks under %0d register settings;",
                 turn_count, tick_count, settings_count);
        $display("%0d results checked, %0d mismatches.", results_checked, error_count);
        if (error_count == 0)
            $display("rotary_knob_accelerated_setpoint_unit regression: pass");
        else
            $display("rotary_knob_accelerated_setpoint_unit regression: fail");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Timeout with %0d results still expected", expected_results.size());
        $display("rotary_knob_accelerated_setpoint_unit regression: fail");
        $finish;
    end

endmodule
